/* rtl/dssm_pkg.sv */
// Shared constants and codes for the dual stack shared memory block.
`timescale 1ns / 1ps

package dssm_pkg;

    // Default number of words in the shared store.
    localparam int DEPTH_DEF = 32;

    // Width of one stored word and of the data fields.
    localparam int DATA_W = 32;

    // Most results that one dump emits.
    localparam int RESULT_CAP = 32;

    // Command codes.
    localparam logic [2:0] CMD_PUSH_LO = 3'd0;
    localparam logic [2:0] CMD_PUSH_HI = 3'd1;
    localparam logic [2:0] CMD_POP_LO  = 3'd2;
    localparam logic [2:0] CMD_POP_HI  = 3'd3;
    localparam logic [2:0] CMD_DUMP_LO = 3'd4;
    localparam logic [2:0] CMD_DUMP_HI = 3'd5;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;

endpackage

/* rtl/dssm_ram.sv */
// Single-port-write, single-port-read synchronous RAM holding both stacks.
`timescale 1ns / 1ps

module dssm_ram #(
    parameter int DEPTH = dssm_pkg::DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [dssm_pkg::DATA_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [dssm_pkg::DATA_W-1:0] o_rdata
);

    logic [dssm_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [dssm_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read; hold the last word when no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/dual_stack_shared_memory.sv */
// Top level: two stacks sharing one RAM, with push, pop and dump commands.
`timescale 1ns / 1ps

// Two stacks share one RAM of DEPTH words: stack one grows up from word 0,
// stack two grows down from word DEPTH-1. A command is taken at a rising edge
// where start is high and busy is low. Every command that causes a result
// shows it on o_data/o_status/o_last in the cycle after it is taken,
// marked by o_strobe for that single cycle; the receiver must take it then.
// Push and pop may be issued back to back, since a push writes the RAM at
// the edge that takes it and a pop reads the RAM at the edge that takes it
// (so the write and read ordering of neighboring commands is naturally
// correct). A dump of a stack holding n entries issues one RAM read per
// cycle on the single read port, keeping busy high after it is taken until
// the last read is issued; its min(n, 32) results stream out one per cycle,
// top of stack first, with o_last on the final one. Dumping an empty
// stack gives one result with the empty status. A push when the two stacks
// together fill the RAM reports overflow and leaves the RAM alone; a pop of
// an empty stack reports empty with data zero. Codes 6 and 7 are taken and
// do nothing. The RAM needs no clearing after reset: only pushed words are
// ever read.

module dual_stack_shared_memory #(
    parameter int DEPTH = dssm_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic [2:0]         i_cmd,
    input  logic signed [31:0] i_push_value,
    output logic               busy,
    output logic               o_strobe,
    output logic signed [31:0] o_data,
    output logic [1:0]         o_status,
    output logic               o_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int RW = $clog2(dssm_pkg::RESULT_CAP + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // Stack fill counts.
    logic [CW-1:0] r_cnt_lo, n_cnt_lo;
    logic [CW-1:0] r_cnt_hi, n_cnt_hi;

    // Dump sequencer: reads still to issue, next address, direction.
    logic [RW-1:0] r_dump_rem, n_dump_rem;
    logic [AW-1:0] r_dump_addr, n_dump_addr;
    logic          r_dump_up, n_dump_up;

    // Result stage.
    logic          r_strobe, n_strobe;
    logic [1:0]    r_status, n_status;
    logic          r_last, n_last;
    logic          r_use_mem, n_use_mem;

    // RAM port.
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [dssm_pkg::DATA_W-1:0] ram_wdata;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [dssm_pkg::DATA_W-1:0] ram_rdata;

    logic [CW:0]   cnt_sum;
    logic          full;
    logic [CW-1:0] hi_push_idx;
    logic [CW-1:0] hi_pop_idx;
    logic [CW-1:0] lo_dec;
    logic [CW-1:0] dump_n;
    logic [RW-1:0] dump_shown;
    logic [CW-1:0] dump_first;

    dssm_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy = (r_dump_rem != '0);

    assign cnt_sum     = {1'b0, r_cnt_lo} + {1'b0, r_cnt_hi};
    assign full        = (cnt_sum >= {1'b0, DEPTH_C});
    assign hi_push_idx = DEPTH_C - CW'(1) - r_cnt_hi;
    assign hi_pop_idx  = DEPTH_C - r_cnt_hi;
    assign lo_dec      = r_cnt_lo - CW'(1);

    // Dump length: entries held, capped at the result limit.
    assign dump_n     = (i_cmd == dssm_pkg::CMD_DUMP_HI) ? r_cnt_hi : r_cnt_lo;
    assign dump_shown = (int'(dump_n) > dssm_pkg::RESULT_CAP) ?
                        RW'(dssm_pkg::RESULT_CAP) : RW'(dump_n);
    // Top of stack: word n-1 for stack one, word DEPTH-n for stack two.
    assign dump_first = (i_cmd == dssm_pkg::CMD_DUMP_HI) ?
                        (DEPTH_C - dump_n) : (dump_n - CW'(1));

    always_comb begin
        n_cnt_lo    = r_cnt_lo;
        n_cnt_hi    = r_cnt_hi;
        n_dump_rem  = r_dump_rem;
        n_dump_addr = r_dump_addr;
        n_dump_up   = r_dump_up;
        n_strobe    = 1'b0;
        n_status    = dssm_pkg::ST_OK;
        n_last      = 1'b1;
        n_use_mem   = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_cnt_lo[AW-1:0];
        ram_wdata   = i_push_value;
        ram_re      = 1'b0;
        ram_raddr   = r_dump_addr;

        if (busy) begin
            // Advance the dump: one read per cycle toward the stack bottom.
            ram_re      = 1'b1;
            ram_raddr   = r_dump_addr;
            n_strobe    = 1'b1;
            n_use_mem   = 1'b1;
            n_last      = (r_dump_rem == RW'(1));
            n_dump_rem  = r_dump_rem - RW'(1);
            n_dump_addr = r_dump_up ? (r_dump_addr + AW'(1)) : (r_dump_addr - AW'(1));
        end else if (start) begin
            unique case (i_cmd)
                dssm_pkg::CMD_PUSH_LO: begin
                    n_strobe = 1'b1;
                    if (full) begin
                        n_status = dssm_pkg::ST_OVERFLOW;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = r_cnt_lo[AW-1:0];
                        n_cnt_lo  = r_cnt_lo + CW'(1);
                    end
                end
                dssm_pkg::CMD_PUSH_HI: begin
                    n_strobe = 1'b1;
                    if (full) begin
                        n_status = dssm_pkg::ST_OVERFLOW;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = hi_push_idx[AW-1:0];
                        n_cnt_hi  = r_cnt_hi + CW'(1);
                    end
                end
                dssm_pkg::CMD_POP_LO: begin
                    n_strobe = 1'b1;
                    if (r_cnt_lo == '0) begin
                        n_status = dssm_pkg::ST_EMPTY;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = lo_dec[AW-1:0];
                        n_use_mem = 1'b1;
                        n_cnt_lo  = lo_dec;
                    end
                end
                dssm_pkg::CMD_POP_HI: begin
                    n_strobe = 1'b1;
                    if (r_cnt_hi == '0) begin
                        n_status = dssm_pkg::ST_EMPTY;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = hi_pop_idx[AW-1:0];
                        n_use_mem = 1'b1;
                        n_cnt_hi  = r_cnt_hi - CW'(1);
                    end
                end
                dssm_pkg::CMD_DUMP_LO,
                dssm_pkg::CMD_DUMP_HI: begin
                    n_strobe = 1'b1;
                    if (dump_n == '0) begin
                        n_status = dssm_pkg::ST_EMPTY;
                    end else begin
                        // Issue the top-of-stack read now, the rest from busy.
                        ram_re      = 1'b1;
                        ram_raddr   = dump_first[AW-1:0];
                        n_use_mem   = 1'b1;
                        n_last      = (dump_shown == RW'(1));
                        n_dump_rem  = dump_shown - RW'(1);
                        n_dump_up   = (i_cmd == dssm_pkg::CMD_DUMP_HI);
                        n_dump_addr = (i_cmd == dssm_pkg::CMD_DUMP_HI) ?
                                      (dump_first[AW-1:0] + AW'(1)) :
                                      (dump_first[AW-1:0] - AW'(1));
                    end
                end
                default: begin
                    // Unused code: drop it, no result.
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_lo   <= '0;
            r_cnt_hi   <= '0;
            r_dump_rem <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_cnt_lo   <= n_cnt_lo;
            r_cnt_hi   <= n_cnt_hi;
            r_dump_rem <= n_dump_rem;
            r_strobe   <= n_strobe;
        end
    end

    // Payload of the result stage and dump address.
    always_ff @(posedge i_clk) begin
        r_dump_addr <= n_dump_addr;
        r_dump_up   <= n_dump_up;
        r_status    <= n_status;
        r_last      <= n_last;
        r_use_mem   <= n_use_mem;
    end

    assign o_strobe = r_strobe;
    assign o_status = r_status;
    assign o_last   = r_last;
    assign o_data   = r_use_mem ? ram_rdata : '0;

    // The two stacks never claim more words than the RAM holds.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_sum <= {1'b0, DEPTH_C})
        else $error("stack counts exceed RAM depth");

    // A dump in flight leaves both stacks untouched.
    a_dump_holds_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> ($stable(r_cnt_lo) && $stable(r_cnt_hi)))
        else $error("stack count changed during dump");

    // A result only follows a taken command or a dump step.
    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start || busy))
        else $error("result without a command");

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the two-stacks-in-one-RAM block: push, pop and dump commands.
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH       = dssm_pkg::DEPTH_DEF;
    localparam int CYCLE_LIMIT = 200000;

    // Codes the block takes and ignores.
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

    // One result item as the block shows it.
    typedef struct {
        logic signed [31:0] data;
        logic [1:0]         status;
        logic               last;
    } t_stack_reply;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               start        = 1'b0;
    logic [2:0]         i_cmd        = dssm_pkg::CMD_PUSH_LO;
    logic signed [31:0] i_push_value = '0;
    logic               busy;
    logic               o_strobe;
    logic signed [31:0] o_data;
    logic [1:0]         o_status;
    logic               o_last;

    dual_stack_shared_memory #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_cmd       (i_cmd),
        .i_push_value(i_push_value),
        .busy        (busy),
        .o_strobe    (o_strobe),
        .o_data      (o_data),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    always #4 i_clk = ~i_clk;

    // Shadow copy of the shared RAM and of both stack depths.
    logic [31:0]  shadow_mem [DEPTH];
    int           lo_count = 0;
    int           hi_count = 0;

    // Results owed by the block, oldest first.
    t_stack_reply replies_due[$];

    int idle_pct        = 0;
    int cmd_items       = 0;
    int replies_checked = 0;
    int overflow_seen   = 0;
    int empty_seen      = 0;
    int error_count     = 0;
    int cycle_count     = 0;

    function automatic void owe_reply(input logic [31:0] data, input logic [1:0] status,
                                      input logic last);
        t_stack_reply r;
        r.data   = data;
        r.status = status;
        r.last   = last;
        replies_due.push_back(r);
    endfunction

    // Apply one accepted command to the shadow state and queue the results it owes.
    function automatic void compute_stack_replies(input logic [2:0] cmd,
                                                  input logic [31:0] value);
        int  held;
        int  shown;
        int  idx;
        bit  full;
        full = (lo_count + hi_count) >= DEPTH;
        case (cmd)
            dssm_pkg::CMD_PUSH_LO: begin
                if (full) begin
                    owe_reply('0, dssm_pkg::ST_OVERFLOW, 1'b1);
                end else begin
                    shadow_mem[lo_count] = value;
                    lo_count++;
                    owe_reply('0, dssm_pkg::ST_OK, 1'b1);
                end
            end
            dssm_pkg::CMD_PUSH_HI: begin
                if (full) begin
                    owe_reply('0, dssm_pkg::ST_OVERFLOW, 1'b1);
                end else begin
                    hi_count++;
                    shadow_mem[DEPTH - hi_count] = value;
                    owe_reply('0, dssm_pkg::ST_OK, 1'b1);
                end
            end
            dssm_pkg::CMD_POP_LO: begin
                if (lo_count == 0) begin
                    owe_reply('0, dssm_pkg::ST_EMPTY, 1'b1);
                end else begin
                    lo_count--;
                    owe_reply(shadow_mem[lo_count], dssm_pkg::ST_OK, 1'b1);
                end
            end
            dssm_pkg::CMD_POP_HI: begin
                if (hi_count == 0) begin
                    owe_reply('0, dssm_pkg::ST_EMPTY, 1'b1);
                end else begin
                    idx = DEPTH - hi_count;
                    hi_count--;
                    owe_reply(shadow_mem[idx], dssm_pkg::ST_OK, 1'b1);
                end
            end
            dssm_pkg::CMD_DUMP_LO, dssm_pkg::CMD_DUMP_HI: begin
                held = (cmd == dssm_pkg::CMD_DUMP_HI) ? hi_count : lo_count;
                if (held == 0) begin
                    owe_reply('0, dssm_pkg::ST_EMPTY, 1'b1);
                end else begin
                    // Top of stack first; cap the stream at RESULT_CAP entries.
                    shown = (held > dssm_pkg::RESULT_CAP) ? dssm_pkg::RESULT_CAP : held;
                    for (int k = 0; k < shown; k++) begin
                        idx = (cmd == dssm_pkg::CMD_DUMP_HI) ? (DEPTH - held + k) :
                                                               (held - 1 - k);
                        owe_reply(shadow_mem[idx], dssm_pkg::ST_OK, k == shown - 1);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Random word, biased toward the sign and all-ones corners.
    function automatic logic [31:0] any_word();
        case ($urandom_range(7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_side(input logic [2:0] lo_cmd, input logic [2:0] hi_cmd);
        return $urandom_range(1) ? hi_cmd : lo_cmd;
    endfunction

    // Send one command item. Idle first at the current sender rate, then hold
    // start high until an edge sees busy low; keep start high on return so a
    // back-to-back item needs no second assignment in the same step.
    task automatic send_cmd(input logic [2:0] cmd, input logic [31:0] value);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_cmd        <= cmd;
        i_push_value <= value;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        compute_stack_replies(cmd, value);
        if (cmd <= dssm_pkg::CMD_DUMP_HI) cmd_items++;
    endtask

    // Drop start and hold off until every owed result has come back.
    task automatic wait_results_done();
        start <= 1'b0;
        @(posedge i_clk);
        while (replies_due.size() != 0) @(posedge i_clk);
    endtask

    // Both stacks empty: pops and dumps report empty; spare codes do nothing.
    task automatic test_empty_stacks();
        send_cmd(dssm_pkg::CMD_POP_LO, any_word());
        send_cmd(dssm_pkg::CMD_POP_HI, any_word());
        send_cmd(dssm_pkg::CMD_DUMP_LO, any_word());
        send_cmd(dssm_pkg::CMD_DUMP_HI, any_word());
        send_cmd(CMD_SPARE_A, any_word());
        send_cmd(CMD_SPARE_B, any_word());
        send_cmd(dssm_pkg::CMD_DUMP_LO, any_word());
    endtask

    // Corner values through both stacks, then pop each past empty.
    task automatic test_value_extremes();
        send_cmd(dssm_pkg::CMD_PUSH_LO, 32'h7FFF_FFFF);
        send_cmd(dssm_pkg::CMD_PUSH_LO, 32'h8000_0000);
        send_cmd(dssm_pkg::CMD_PUSH_HI, 32'hFFFF_FFFF);
        send_cmd(dssm_pkg::CMD_PUSH_HI, 32'h0000_0000);
        send_cmd(dssm_pkg::CMD_PUSH_HI, 32'hAAAA_5555);
        send_cmd(dssm_pkg::CMD_DUMP_LO, '0);
        send_cmd(dssm_pkg::CMD_DUMP_HI, '0);
        repeat (4) send_cmd(dssm_pkg::CMD_POP_HI, any_word());
        repeat (3) send_cmd(dssm_pkg::CMD_POP_LO, any_word());
        wait_results_done();
    endtask

    // Empty both stacks, fill the RAM with a random split, push past full on
    // each side, and dump both.
    task automatic fill_store(input int lo_pct);
        while (lo_count > 0) send_cmd(dssm_pkg::CMD_POP_LO, any_word());
        while (hi_count > 0) send_cmd(dssm_pkg::CMD_POP_HI, any_word());
        while (lo_count + hi_count < DEPTH)
            send_cmd(($urandom_range(99) < lo_pct) ? dssm_pkg::CMD_PUSH_LO :
                                                    dssm_pkg::CMD_PUSH_HI, any_word());
        send_cmd(dssm_pkg::CMD_PUSH_LO, any_word());
        send_cmd(dssm_pkg::CMD_PUSH_HI, any_word());
        send_cmd(dssm_pkg::CMD_DUMP_LO, any_word());
        send_cmd(dssm_pkg::CMD_DUMP_HI, any_word());
    endtask

    // Mostly well-formed push/pop/dump runs with random content, plus fills,
    // drains past empty, pauses for a quiet block, and some noise codes.
    task automatic test_random_traffic(input int sender_idle, input int fill_lo_pct,
                                       input int item_goal);
        int       pick;
        int       n;
        int       goal_end;
        logic [2:0] side_cmd;
        idle_pct = sender_idle;
        goal_end = cmd_items + item_goal;
        fill_store(fill_lo_pct);
        while (cmd_items < goal_end) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                n = $urandom_range(10, 2);
                repeat (n) begin
                    send_cmd(pick_side(dssm_pkg::CMD_PUSH_LO, dssm_pkg::CMD_PUSH_HI),
                             any_word());
                end
            end else if (pick < 55) begin
                n = $urandom_range(6, 1);
                repeat (n) begin
                    send_cmd(pick_side(dssm_pkg::CMD_POP_LO, dssm_pkg::CMD_POP_HI),
                             any_word());
                end
            end else if (pick < 70) begin
                send_cmd(pick_side(dssm_pkg::CMD_DUMP_LO, dssm_pkg::CMD_DUMP_HI), any_word());
            end else if (pick < 76) begin
                fill_store($urandom_range(100));
            end else if (pick < 84) begin
                // Drain one side and pop once more to hit empty.
                side_cmd = pick_side(dssm_pkg::CMD_POP_LO, dssm_pkg::CMD_POP_HI);
                n = ((side_cmd == dssm_pkg::CMD_POP_LO) ? lo_count : hi_count) + 1;
                repeat (n) send_cmd(side_cmd, any_word());
            end else if (pick < 90) begin
                wait_results_done();
                send_cmd(3'($urandom_range(dssm_pkg::CMD_DUMP_HI)), any_word());
            end else begin
                send_cmd(3'($urandom_range(7)), any_word());
            end
        end
    endtask

    // Check each strobed result against the oldest owed one.
    always @(posedge i_clk) begin
        t_stack_reply want;
        if (i_rst_n && o_strobe) begin
            if (replies_due.size() == 0) begin
                $display("%0t: unexpected result: expected none, got data=%h status=%0d %s%0b",
                         $time, o_data, o_status, "last=", o_last);
                error_count++;
            end else begin
                want = replies_due.pop_front();
                replies_checked++;
                if (want.status == dssm_pkg::ST_OVERFLOW) overflow_seen++;
                if (want.status == dssm_pkg::ST_EMPTY) empty_seen++;
                if (o_data !== want.data || o_status !== want.status || o_last !== want.last)
                begin
                    $display("%0t: mismatch: expected data=%h status=%0d last=%0b,",
                             $time, want.data, want.status, want.last);
                    $display("%0t:           got data=%h status=%0d last=%0b",
                             $time, o_data, o_status, o_last);
                    error_count++;
                end
            end
        end
    end

    // Stop a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results still owed", $time, replies_due.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_stacks();
        test_value_extremes();

        // Sender idles rarely, then often, then never.
        test_random_traffic(16, 100, 60);
        wait_results_done();
        test_random_traffic(71, 0, 60);
        wait_results_done();
        test_random_traffic(0, 50, 60);
        wait_results_done();

        // Catch any stray result after the last owed one.
        repeat (dssm_pkg::RESULT_CAP + 8) @(posedge i_clk);

        $display("Covered %0d push/pop/dump items and %0d results, incl. full-RAM dumps,",
                 cmd_items, replies_checked);
        $display("%0d overflow and %0d empty reports, under three sender idle rates.",
                 overflow_seen, empty_seen);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
